// ===== sv/ellsf_pkg.sv =====
// Package of the exponential least-squares fit block: sequencer states, widths
// and fixed-point constants. No dependencies.
package ellsf_pkg;

	// Width of the shared multiplier operands and of the divider words.
	localparam int unsigned OPW = 64;
	localparam int unsigned WW  = 128;

	// ln(2) in Q30.
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	// Intercept clamp, 12.0 in Q16.
	localparam logic [19:0] ICPT_LIMIT = 20'd786432;
	// Time-constant saturation bounds in Q24.12.
	localparam logic [35:0] RC_POS_LIMIT = 36'h7FFFFFFFF;
	localparam logic [35:0] RC_NEG_LIMIT = 36'h800000000;

	// Fit status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
	localparam logic [1:0] STAT_BAD_VOLT = 2'd2;
	localparam logic [1:0] STAT_SLOPE0   = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LN_MUL, ST_LN_WAIT,
		ST_LG_MUL, ST_LG_WAIT,
		ST_TT_MUL, ST_TT_WAIT,
		ST_TL_MUL, ST_TL_WAIT,
		ST_ACC,
		ST_F_LHS, ST_F_LHS_W,
		ST_F_RHS, ST_F_RHS_W,
		ST_F_PA, ST_F_PA_W,
		ST_F_PB, ST_F_PB_W,
		ST_F_PC, ST_F_PC_W,
		ST_F_PD, ST_F_PD_W,
		ST_D_ICPT, ST_D_ICPT_W,
		ST_E_RED,
		ST_E_MUL, ST_E_MUL_W,
		ST_E_DIV, ST_E_DIV_W,
		ST_E_FIN,
		ST_R_DIV, ST_R_DIV_W,
		ST_EMIT
	} state_t;

endpackage

// ===== sv/exponential_least_squares_fit.sv =====
// Exponential least-squares fit: top level with the sequencer and datapath.
// Depends on ellsf_pkg, ellsf_mul and ellsf_div.
//
// This block fits y = V0*exp(b*t) to a run of samples. Each input transaction
// carries a time (unsigned Q12.12) and a voltage (unsigned Q8.16); tlast marks
// the final sample of a run. A sample passes through a normalizing priority
// encode, sixteen squarings for log2 of the voltage, a scale to ln, and two
// products for the sums. Each of these short products runs on the one shared
// 32x32 multiplier, so s_tready stays low from the accepted sample until the
// sequencer is idle again. A sample with zero voltage is not summed and marks
// the run bad; once the run holds MAX_POINTS samples further samples are
// dropped, although tlast still ends the run. On the last sample the normal
// equations are solved with the shared multiplier and a one-bit-per-cycle
// divider; a fit with a nonzero slope uses fifteen divides (intercept, thirteen
// Taylor terms of the exponential, and the time constant). One result
// transaction follows with V0 (Q16.16), RC = -1/b (Q24.12), the number of
// samples used and the status on m_tuser (0 ok, 1 zero denominator, 2
// non-positive voltage seen, 3 slope zero). The run sums are then cleared.
module exponential_least_squares_fit #(
	parameter int MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // sample_time[23:0], sample_voltage[47:24]
	input  logic        s_tlast,  // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // initial_voltage[31:0], time_constant[67:32],
	                              // points_used[78:68], zero fill[79]
	output logic [1:0]  m_tuser   // fit_status[1:0]
);

	ellsf_pkg::state_t state_q, state_d;

	// Run sums.
	logic [10:0]        cnt_q;
	logic [33:0]        sx_q;
	logic [57:0]        sxx_q;
	logic signed [33:0] sl_q;
	logic signed [57:0] stl_q;
	logic               bad_q;

	// Accepted sample.
	logic [23:0] tm_q, volt_q;
	logic        last_q;

	// Logarithm.
	logic [4:0]         top_q;
	logic [31:0]        z_q;
	logic [15:0]        frac_q;
	logic [3:0]         it_q;
	logic signed [21:0] lv_q;

	// Fit.
	logic [127:0]        lhs_q, den_q;
	logic signed [129:0] part_q;
	logic                na_neg_q, nb_neg_q;
	logic [127:0]        na_mag_q, nb_mag_q;
	logic signed [35:0]  r_q;
	logic signed [5:0]   k_q;
	logic [31:0]         term_q, e_q, t_q;
	logic [3:0]          m_q;
	logic [31:0]         res_v0_q;
	logic [35:0]         res_rc_q;
	logic [1:0]          res_st_q;

	// Output register.
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// Shared units.
	logic         mul_start, mul_done;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mul_prod;
	logic         div_start, div_done;
	logic [127:0] div_num, div_den, div_quo;

	ellsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ellsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Signed view of a product magnitude.
	function automatic logic signed [129:0] to_signed(input logic [127:0] mag,
	                                                  input logic neg);
		logic signed [129:0] v;
		v = $signed({2'b00, mag});
		return neg ? -v : v;
	endfunction

	// Index of the top set bit of the voltage.
	logic [4:0] top_d;
	always_comb begin
		top_d = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (volt_q[i]) begin
				top_d = 5'(i);
			end
		end
	end

	// Log2 in Q16 as a concatenation of the exponent and the fraction bits.
	logic signed [5:0]  l2_hi;
	logic signed [21:0] l2;
	logic [20:0]        l2_mag;
	always_comb begin
		l2_hi  = $signed({1'b0, top_q}) - 6'sd16;
		l2     = $signed({l2_hi, frac_q});
		l2_mag = l2[21] ? 21'(-l2) : 21'(l2);
	end

	// Magnitudes of the signed sums.
	logic [20:0] lv_mag;
	logic [33:0] sl_mag;
	logic [57:0] stl_mag;
	always_comb begin
		lv_mag  = lv_q[21] ? 21'(-lv_q) : 21'(lv_q);
		sl_mag  = sl_q[33] ? 34'(-sl_q) : 34'(sl_q);
		stl_mag = stl_q[57] ? 58'(-stl_q) : 58'(stl_q);
	end

	// Derived values for the datapath.
	logic [31:0]         zz;
	logic [20:0]         lg_round;
	logic signed [129:0] diff;
	logic [127:0]        diff_mag;
	logic [19:0]         icpt_mag;
	logic signed [35:0]  xr;
	logic [35:0]         rc_lim, rc_q;
	logic [31:0]         v0;
	logic [6:0]          amt;
	logic [63:0]         e_round;
	logic [33:0]         e_up;
	always_comb begin
		zz       = mul_prod[61:30];
		lg_round = 21'((mul_prod[50:0] + 51'd536870912) >> 30);
		diff     = part_q - to_signed(mul_prod, (state_q == ellsf_pkg::ST_F_PB_W) ?
		           stl_q[57] : sl_q[33]);
		diff_mag = diff[129] ? 128'(-diff) : 128'(diff);
		icpt_mag = (div_quo > 128'(ellsf_pkg::ICPT_LIMIT)) ? ellsf_pkg::ICPT_LIMIT
		           : div_quo[19:0];
		xr       = na_neg_q ? -$signed({2'b00, icpt_mag, 14'd0})
		           : $signed({2'b00, icpt_mag, 14'd0});
		rc_lim   = nb_neg_q ? ellsf_pkg::RC_POS_LIMIT : ellsf_pkg::RC_NEG_LIMIT;
		rc_q     = (div_quo > 128'(rc_lim)) ? rc_lim : div_quo[35:0];
		// Scale the series sum by 2^(k-14), rounding or saturating.
		amt      = 7'(7'sd14 - 7'(k_q));
		e_round  = (64'(e_q) + (64'd1 << (amt - 7'd1))) >> amt;
		e_up     = {2'b00, e_q} << (k_q[1:0] - 2'd2);
		if (k_q >= 6'sd16) begin
			v0 = 32'hFFFFFFFF;
		end else if (k_q >= 6'sd14) begin
			v0 = (e_up[33:32] != 2'd0) ? 32'hFFFFFFFF : e_up[31:0];
		end else if (amt > 7'd62) begin
			v0 = 32'd0;
		end else begin
			v0 = e_round[31:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ellsf_pkg::ST_IDLE:     if (s_tvalid) state_d = ellsf_pkg::ST_CHECK;
			ellsf_pkg::ST_CHECK: begin
				if (cnt_q >= 11'(MAX_POINTS) || volt_q == 24'd0) begin
					state_d = last_q ? ellsf_pkg::ST_F_LHS : ellsf_pkg::ST_IDLE;
				end else begin
					state_d = ellsf_pkg::ST_LN_MUL;
				end
			end
			ellsf_pkg::ST_LN_MUL:   state_d = ellsf_pkg::ST_LN_WAIT;
			ellsf_pkg::ST_LN_WAIT: begin
				if (mul_done) begin
					state_d = (it_q == 4'd15) ? ellsf_pkg::ST_LG_MUL : ellsf_pkg::ST_LN_MUL;
				end
			end
			ellsf_pkg::ST_LG_MUL:   state_d = ellsf_pkg::ST_LG_WAIT;
			ellsf_pkg::ST_LG_WAIT:  if (mul_done) state_d = ellsf_pkg::ST_TT_MUL;
			ellsf_pkg::ST_TT_MUL:   state_d = ellsf_pkg::ST_TT_WAIT;
			ellsf_pkg::ST_TT_WAIT:  if (mul_done) state_d = ellsf_pkg::ST_TL_MUL;
			ellsf_pkg::ST_TL_MUL:   state_d = ellsf_pkg::ST_TL_WAIT;
			ellsf_pkg::ST_TL_WAIT:  if (mul_done) state_d = ellsf_pkg::ST_ACC;
			ellsf_pkg::ST_ACC:
				state_d = last_q ? ellsf_pkg::ST_F_LHS : ellsf_pkg::ST_IDLE;
			ellsf_pkg::ST_F_LHS:    state_d = ellsf_pkg::ST_F_LHS_W;
			ellsf_pkg::ST_F_LHS_W:  if (mul_done) state_d = ellsf_pkg::ST_F_RHS;
			ellsf_pkg::ST_F_RHS:    state_d = ellsf_pkg::ST_F_RHS_W;
			ellsf_pkg::ST_F_RHS_W: begin
				if (mul_done) begin
					state_d = (bad_q || mul_prod >= lhs_q) ? ellsf_pkg::ST_EMIT
					          : ellsf_pkg::ST_F_PA;
				end
			end
			ellsf_pkg::ST_F_PA:     state_d = ellsf_pkg::ST_F_PA_W;
			ellsf_pkg::ST_F_PA_W:   if (mul_done) state_d = ellsf_pkg::ST_F_PB;
			ellsf_pkg::ST_F_PB:     state_d = ellsf_pkg::ST_F_PB_W;
			ellsf_pkg::ST_F_PB_W:   if (mul_done) state_d = ellsf_pkg::ST_F_PC;
			ellsf_pkg::ST_F_PC:     state_d = ellsf_pkg::ST_F_PC_W;
			ellsf_pkg::ST_F_PC_W:   if (mul_done) state_d = ellsf_pkg::ST_F_PD;
			ellsf_pkg::ST_F_PD:     state_d = ellsf_pkg::ST_F_PD_W;
			ellsf_pkg::ST_F_PD_W:   if (mul_done) state_d = ellsf_pkg::ST_D_ICPT;
			ellsf_pkg::ST_D_ICPT:   state_d = ellsf_pkg::ST_D_ICPT_W;
			ellsf_pkg::ST_D_ICPT_W: if (div_done) state_d = ellsf_pkg::ST_E_RED;
			ellsf_pkg::ST_E_RED: begin
				if (!r_q[35] && r_q < 36'sd744261118) state_d = ellsf_pkg::ST_E_MUL;
			end
			ellsf_pkg::ST_E_MUL:    state_d = ellsf_pkg::ST_E_MUL_W;
			ellsf_pkg::ST_E_MUL_W:  if (mul_done) state_d = ellsf_pkg::ST_E_DIV;
			ellsf_pkg::ST_E_DIV:    state_d = ellsf_pkg::ST_E_DIV_W;
			ellsf_pkg::ST_E_DIV_W: begin
				if (div_done) begin
					state_d = (m_q == 4'd13) ? ellsf_pkg::ST_E_FIN : ellsf_pkg::ST_E_MUL;
				end
			end
			ellsf_pkg::ST_E_FIN:
				state_d = (nb_mag_q == '0) ? ellsf_pkg::ST_EMIT : ellsf_pkg::ST_R_DIV;
			ellsf_pkg::ST_R_DIV:    state_d = ellsf_pkg::ST_R_DIV_W;
			ellsf_pkg::ST_R_DIV_W:  if (div_done) state_d = ellsf_pkg::ST_EMIT;
			ellsf_pkg::ST_EMIT:     if (!m_tvalid_q) state_d = ellsf_pkg::ST_IDLE;
			default:                state_d = ellsf_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: shared unit operands and the input handshake.
	always_comb begin
		s_tready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ellsf_pkg::ST_IDLE: s_tready = 1'b1;
			ellsf_pkg::ST_LN_MUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(z_q);
				mul_b     = 64'(z_q);
			end
			ellsf_pkg::ST_LG_MUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(l2_mag);
				mul_b     = 64'(ellsf_pkg::LN2_Q30);
			end
			ellsf_pkg::ST_TT_MUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(tm_q);
				mul_b     = 64'(tm_q);
			end
			ellsf_pkg::ST_TL_MUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(tm_q);
				mul_b     = 64'(lv_mag);
			end
			ellsf_pkg::ST_F_LHS: begin
				mul_start = 1'b1;
				mul_a     = 64'(cnt_q);
				mul_b     = 64'(sxx_q);
			end
			ellsf_pkg::ST_F_RHS: begin
				mul_start = 1'b1;
				mul_a     = 64'(sx_q);
				mul_b     = 64'(sx_q);
			end
			ellsf_pkg::ST_F_PA: begin
				mul_start = 1'b1;
				mul_a     = 64'(sxx_q);
				mul_b     = 64'(sl_mag);
			end
			ellsf_pkg::ST_F_PB: begin
				mul_start = 1'b1;
				mul_a     = 64'(sx_q);
				mul_b     = 64'(stl_mag);
			end
			ellsf_pkg::ST_F_PC: begin
				mul_start = 1'b1;
				mul_a     = 64'(cnt_q);
				mul_b     = 64'(stl_mag);
			end
			ellsf_pkg::ST_F_PD: begin
				mul_start = 1'b1;
				mul_a     = 64'(sx_q);
				mul_b     = 64'(sl_mag);
			end
			ellsf_pkg::ST_E_MUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(term_q);
				mul_b     = 64'(r_q[29:0]);
			end
			ellsf_pkg::ST_D_ICPT: begin
				div_start = 1'b1;
				div_num   = na_mag_q + {1'b0, den_q[127:1]};
				div_den   = den_q;
			end
			ellsf_pkg::ST_E_DIV: begin
				div_start = 1'b1;
				div_num   = 128'(t_q);
				div_den   = 128'(m_q);
			end
			ellsf_pkg::ST_R_DIV: begin
				div_start = 1'b1;
				div_num   = {den_q[111:0], 16'd0} + {1'b0, nb_mag_q[127:1]};
				div_den   = nb_mag_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ellsf_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			cnt_q      <= 11'd0;
			bad_q      <= 1'b0;
			sx_q       <= '0;
			sxx_q      <= '0;
			sl_q       <= '0;
			stl_q      <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ellsf_pkg::ST_CHECK: begin
					if (cnt_q < 11'(MAX_POINTS) && volt_q == 24'd0) begin
						bad_q <= 1'b1;
					end
				end
				ellsf_pkg::ST_TT_WAIT: if (mul_done) sxx_q <= sxx_q + mul_prod[57:0];
				ellsf_pkg::ST_TL_WAIT: begin
					if (mul_done) begin
						stl_q <= lv_q[21] ? stl_q - $signed(mul_prod[57:0])
						         : stl_q + $signed(mul_prod[57:0]);
					end
				end
				ellsf_pkg::ST_ACC: begin
					sx_q  <= sx_q + 34'(tm_q);
					sl_q  <= sl_q + 34'(lv_q);
					cnt_q <= cnt_q + 11'd1;
				end
				ellsf_pkg::ST_EMIT: begin
					if (!m_tvalid_q) begin
						// Result goes out and the run starts afresh.
						m_tvalid_q <= 1'b1;
						cnt_q      <= 11'd0;
						bad_q      <= 1'b0;
						sx_q       <= '0;
						sxx_q      <= '0;
						sl_q       <= '0;
						stl_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ellsf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					tm_q   <= s_tdata[23:0];
					volt_q <= s_tdata[47:24];
					last_q <= s_tlast;
				end
			end
			ellsf_pkg::ST_CHECK: begin
				// Normalize the voltage to Q1.30 in [1,2).
				top_q  <= top_d;
				z_q    <= 32'(volt_q) << (5'd30 - top_d);
				frac_q <= 16'd0;
				it_q   <= 4'd0;
			end
			ellsf_pkg::ST_LN_WAIT: begin
				if (mul_done) begin
					z_q    <= zz[31] ? {1'b0, zz[31:1]} : zz;
					frac_q <= {frac_q[14:0], zz[31]};
					it_q   <= it_q + 4'd1;
				end
			end
			ellsf_pkg::ST_LG_WAIT: begin
				if (mul_done) begin
					lv_q <= l2[21] ? -$signed({1'b0, lg_round}) : $signed({1'b0, lg_round});
				end
			end
			ellsf_pkg::ST_F_LHS_W: if (mul_done) lhs_q <= mul_prod;
			ellsf_pkg::ST_F_RHS_W: begin
				if (mul_done) begin
					den_q    <= lhs_q - mul_prod;
					res_v0_q <= 32'd0;
					res_rc_q <= 36'd0;
					res_st_q <= bad_q ? ellsf_pkg::STAT_BAD_VOLT : ellsf_pkg::STAT_ZERO_DEN;
				end
			end
			ellsf_pkg::ST_F_PA_W: if (mul_done) part_q <= to_signed(mul_prod, sl_q[33]);
			ellsf_pkg::ST_F_PB_W: begin
				if (mul_done) begin
					na_neg_q <= diff[129];
					na_mag_q <= diff_mag;
				end
			end
			ellsf_pkg::ST_F_PC_W: if (mul_done) part_q <= to_signed(mul_prod, stl_q[57]);
			ellsf_pkg::ST_F_PD_W: begin
				if (mul_done) begin
					nb_neg_q <= diff[129];
					nb_mag_q <= diff_mag;
				end
			end
			ellsf_pkg::ST_D_ICPT_W: begin
				if (div_done) begin
					r_q <= xr;
					k_q <= 6'sd0;
				end
			end
			ellsf_pkg::ST_E_RED: begin
				// Reduce by ln(2) until the remainder lies in [0, ln 2).
				if (r_q[35]) begin
					r_q <= r_q + 36'sd744261118;
					k_q <= k_q - 6'sd1;
				end else if (r_q >= 36'sd744261118) begin
					r_q <= r_q - 36'sd744261118;
					k_q <= k_q + 6'sd1;
				end else begin
					term_q <= 32'h40000000;
					e_q    <= 32'h40000000;
					m_q    <= 4'd1;
				end
			end
			ellsf_pkg::ST_E_MUL_W: if (mul_done) t_q <= mul_prod[61:30];
			ellsf_pkg::ST_E_DIV_W: begin
				if (div_done) begin
					term_q <= div_quo[31:0];
					e_q    <= e_q + div_quo[31:0];
					m_q    <= m_q + 4'd1;
				end
			end
			ellsf_pkg::ST_E_FIN: begin
				res_v0_q <= v0;
				res_rc_q <= 36'd0;
				res_st_q <= (nb_mag_q == '0) ? ellsf_pkg::STAT_SLOPE0 : ellsf_pkg::STAT_OK;
			end
			ellsf_pkg::ST_R_DIV_W: begin
				if (div_done) begin
					res_rc_q <= nb_neg_q ? rc_q : 36'(-rc_q);
				end
			end
			ellsf_pkg::ST_EMIT: begin
				if (!m_tvalid_q) begin
					m_tdata_q <= {1'b0, cnt_q, res_rc_q, res_v0_q};
					m_tuser_q <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/ellsf_mul.sv =====
// Shared wide multiplier: 64x64 unsigned product built from 32x32 partial
// products, one per cycle, registered before accumulation. Uses ellsf_pkg.
module ellsf_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ellsf_pkg::OPW-1:0]     a,
	input  logic [ellsf_pkg::OPW-1:0]     b,
	output logic                          done,
	output logic [ellsf_pkg::WW-1:0]      prod
);

	logic [63:0]  a_q, b_q;
	logic [1:0]   idx_q;
	logic         short_q, busy_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic         vld_s1, last_s1;
	logic [127:0] acc_q;
	logic         done_q;
	logic [31:0]  ah, bh;
	logic         last_pp;

	always_comb begin
		ah = idx_q[1] ? a_q[63:32] : a_q[31:0];
		bh = idx_q[0] ? b_q[63:32] : b_q[31:0];
		last_pp = short_q || (idx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1 && last_s1;
			vld_s1 <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last_pp) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q     <= a;
			b_q     <= b;
			idx_q   <= 2'd0;
			short_q <= (a[63:32] == 32'd0) && (b[63:32] == 32'd0);
			acc_q   <= '0;
		end else begin
			if (busy_q) begin
				idx_q <= idx_q + 2'd1;
			end
			if (vld_s1) begin
				case (sh_s1)
					2'd0:    acc_q <= acc_q + {64'd0, pp_s1};
					2'd1:    acc_q <= acc_q + {32'd0, pp_s1, 32'd0};
					default: acc_q <= acc_q + {pp_s1, 64'd0};
				endcase
			end
		end
		pp_s1   <= 64'(ah) * 64'(bh);
		sh_s1   <= (idx_q == 2'd0) ? 2'd0 : ((idx_q == 2'd3) ? 2'd2 : 2'd1);
		last_s1 <= last_pp;
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== sv/ellsf_div.sv =====
// Shared restoring divider: 128-bit unsigned quotient, one bit per cycle.
// Uses ellsf_pkg.
module ellsf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ellsf_pkg::WW-1:0]  num,
	input  logic [ellsf_pkg::WW-1:0]  den,
	output logic                      done,
	output logic [ellsf_pkg::WW-1:0]  quo
);

	logic [127:0] num_q, den_q, quo_q;
	logic [128:0] rem_q;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q;
	logic [128:0] rem_sh, rem_sub;
	logic         ge;

	always_comb begin
		rem_sh  = {rem_q[127:0], num_q[127]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == 7'd0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= 7'd127;
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= ge ? rem_sub : rem_sh;
			quo_q <= {quo_q[126:0], ge};
			cnt_q <= cnt_q - 7'd1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
